@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked check that is disabled while reset is held.
`define MIO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also holds during reset.
`define MIO_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

@@ rtl/mio_pkg.sv @@
// Shared constants for the max interval overlap block.
// No dependencies.
package mio_pkg;
  localparam int unsigned GUEST_DEPTH_DEF = 1024;
  localparam int unsigned TIME_BITS_DEF   = 32;
  localparam int unsigned IN_TIME_W       = 32;
  localparam int unsigned OVL_W           = 12;
  localparam int          OVL_CAP         = 2047;
endpackage

@@ rtl/mio_if.sv @@
// Valid/ready channel interfaces for guest input and overlap result.
// Depends on mio_pkg.
interface mio_in_if;
  logic                            valid;
  logic                            ready;
  logic [mio_pkg::IN_TIME_W-1:0]   arrival_time;
  logic [mio_pkg::IN_TIME_W-1:0]   departure_time;
  logic                            last_guest;
  modport source (output valid, arrival_time, departure_time, last_guest, input ready);
  modport sink   (input valid, arrival_time, departure_time, last_guest, output ready);
endinterface

interface mio_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [mio_pkg::OVL_W-1:0] max_overlap;
  logic                            overflow;
  modport source (output valid, max_overlap, overflow, input ready);
  modport sink   (input valid, max_overlap, overflow, output ready);
endinterface

@@ rtl/mio_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mio_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/max_interval_overlap_top.sv @@
// Load: one guest per cycle. After the last guest, both stores are bubble
// sorted in place: (n-1) passes on the RAM read/write ports.
// Sweep: each step is a read state, as the RAM read is registered, then a compare state;
// at most 2n-1 steps, then the result is emitted once the output register is free.
// Next set loads while the result waits. Async active-low reset clears control; stores are not cleared.
module max_interval_overlap_top #(
  parameter int unsigned GUEST_DEPTH = mio_pkg::GUEST_DEPTH_DEF,
  parameter int unsigned TIME_BITS   = mio_pkg::TIME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mio_in_if.sink    in_ch_i,
  mio_out_if.source out_ch_o
);
  localparam int unsigned AW  = (GUEST_DEPTH > 1) ? $clog2(GUEST_DEPTH) : 1;
  localparam int unsigned NW  = $clog2(GUEST_DEPTH + 1);
  localparam int unsigned CW  = NW + 1;

  typedef enum logic [7:0] {
    ST_LOAD  = 8'b0000_0001,
    ST_PRIME = 8'b0000_0010,
    ST_LOAD0 = 8'b0000_0100,
    ST_RUN   = 8'b0000_1000,
    ST_FLUSH = 8'b0001_0000,
    ST_SW_RD = 8'b0010_0000,
    ST_SW_CM = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [NW-1:0] cnt_q, cnt_d, j_q, j_d, pass_q, pass_d, ai_q, ai_d, di_q, di_d;
  logic          drop_q, drop_d;
  logic signed [CW-1:0] count_q, count_d, best_q, best_d, count_nx;
  logic [TIME_BITS-1:0] cur_a_q, cur_a_d, cur_d_q, cur_d_d;
  logic                 ovalid_q, ovalid_d;
  logic signed [mio_pkg::OVL_W-1:0] oval_q, oval_d;
  logic                 oflow_q, oflow_d;

  logic                 we;
  logic [AW-1:0]        waddr, raddr_a, raddr_d;
  logic [TIME_BITS-1:0] wdata_a, wdata_d, rdata_a, rdata_d;
  logic                 in_fire;
  logic [NW-1:0]        n_m1;
  logic [NW-1:0]        ai_nx, di_nx;

  mio_ram #(.WIDTH(TIME_BITS), .DEPTH(GUEST_DEPTH)) u_arr_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata_a),
    .raddr_i(raddr_a), .rdata_o(rdata_a)
  );
  mio_ram #(.WIDTH(TIME_BITS), .DEPTH(GUEST_DEPTH)) u_dep_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata_d),
    .raddr_i(raddr_d), .rdata_o(rdata_d)
  );

  assign in_ch_i.ready      = (state_q == ST_LOAD);
  assign in_fire            = in_ch_i.valid && in_ch_i.ready;
  assign out_ch_o.valid     = ovalid_q;
  assign out_ch_o.max_overlap = oval_q;
  assign out_ch_o.overflow  = oflow_q;
  assign n_m1               = cnt_q - NW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    drop_d   = drop_q;
    j_d      = j_q;
    pass_d   = pass_q;
    ai_d     = ai_q;
    di_d     = di_q;
    count_d  = count_q;
    best_d   = best_q;
    cur_a_d  = cur_a_q;
    cur_d_d  = cur_d_q;
    ovalid_d = ovalid_q && !out_ch_o.ready;
    oval_d   = oval_q;
    oflow_d  = oflow_q;
    we       = 1'b0;
    waddr    = cnt_q[AW-1:0];
    wdata_a  = TIME_BITS'(in_ch_i.arrival_time);
    wdata_d  = TIME_BITS'(in_ch_i.departure_time);
    raddr_a  = j_q[AW-1:0];
    raddr_d  = j_q[AW-1:0];
    count_nx = count_q;
    ai_nx    = ai_q;
    di_nx    = di_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_q < NW'(GUEST_DEPTH)) begin
            we    = 1'b1;
            cnt_d = cnt_q + NW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_ch_i.last_guest) begin
            pass_d  = '0;
            state_d = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        ai_d    = '0;
        di_d    = '0;
        count_d = '0;
        best_d  = -CW'(1);
        raddr_a = '0;
        raddr_d = '0;
        j_d     = '0;
        state_d = (cnt_q < NW'(2)) ? ST_SW_RD : ST_LOAD0;
      end
      ST_LOAD0: begin
        cur_a_d = rdata_a;
        cur_d_d = rdata_d;
        raddr_a = AW'(1);
        raddr_d = AW'(1);
        j_d     = NW'(1);
        state_d = ST_RUN;
      end
      ST_RUN: begin
        // carry the larger value forward, drop the smaller one behind it
        we    = 1'b1;
        waddr = AW'(j_q - NW'(1));
        if (cur_a_q > rdata_a) begin
          wdata_a = rdata_a;
        end else begin
          wdata_a = cur_a_q;
          cur_a_d = rdata_a;
        end
        if (cur_d_q > rdata_d) begin
          wdata_d = rdata_d;
        end else begin
          wdata_d = cur_d_q;
          cur_d_d = rdata_d;
        end
        if (j_q == n_m1) begin
          state_d = ST_FLUSH;
        end else begin
          raddr_a = AW'(j_q + NW'(1));
          raddr_d = AW'(j_q + NW'(1));
          j_d     = j_q + NW'(1);
        end
      end
      ST_FLUSH: begin
        we      = 1'b1;
        waddr   = n_m1[AW-1:0];
        wdata_a = cur_a_q;
        wdata_d = cur_d_q;
        pass_d  = pass_q + NW'(1);
        state_d = (pass_q + NW'(1) == n_m1) ? ST_SW_RD : ST_PRIME;
      end
      ST_SW_RD: begin
        raddr_a = ai_q[AW-1:0];
        raddr_d = di_q[AW-1:0];
        state_d = ST_SW_CM;
      end
      ST_SW_CM: begin
        if (rdata_a <= rdata_d) begin
          count_nx = count_q + CW'(1);
          ai_nx    = ai_q + NW'(1);
        end else begin
          count_nx = count_q - CW'(1);
          di_nx    = di_q + NW'(1);
        end
        count_d = count_nx;
        ai_d    = ai_nx;
        di_d    = di_nx;
        if (count_nx > best_q) begin
          best_d = count_nx;
        end
        state_d = (ai_nx == cnt_q || di_nx == cnt_q) ? ST_EMIT : ST_SW_RD;
      end
      ST_EMIT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          oval_d   = (32'(best_q) > mio_pkg::OVL_CAP) ? mio_pkg::OVL_W'(mio_pkg::OVL_CAP)
                                                      : mio_pkg::OVL_W'(best_q);
          oflow_d  = drop_q;
          cnt_d    = '0;
          drop_d   = 1'b0;
          state_d  = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      drop_q   <= 1'b0;
      ovalid_q <= 1'b0;
      j_q      <= '0;
      pass_q   <= '0;
      ai_q     <= '0;
      di_q     <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      drop_q   <= drop_d;
      ovalid_q <= ovalid_d;
      j_q      <= j_d;
      pass_q   <= pass_d;
      ai_q     <= ai_d;
      di_q     <= di_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    best_q  <= best_d;
    cur_a_q <= cur_a_d;
    cur_d_q <= cur_d_d;
    oval_q  <= oval_d;
    oflow_q <= oflow_d;
  end
endmodule

@@ rtl/mio_checker.sv @@
// Port-level checks for max_interval_overlap_top, attached by bind.
// Depends on mio_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mio_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_last_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [mio_pkg::OVL_W-1:0] out_max_i
);
  `MIO_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `MIO_ASSERT(a_out_stable, out_valid_i && !out_ready_i |=> $stable(out_max_i), "result changed")
  `MIO_ASSERT(a_last_closes, in_valid_i && in_ready_i && in_last_i |=> !in_ready_i, "input open after last")
  `MIO_ASSERT(a_emit_after_sweep, $rose(out_valid_i) |-> $past(!in_ready_i), "result while loading")
  `MIO_ASSERT_RST(a_rst_idle, !rst_ni |=> !out_valid_i, "result in reset")
endmodule

bind max_interval_overlap_top mio_checker u_mio_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .in_last_i   (in_ch_i.last_guest),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_max_i   (out_ch_o.max_overlap)
);
